[rtl/sfold_pkg.sv]
// shared types, codes and the saturating add helper for the spherical fold pipeline
package sfold_pkg;

    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = 8;
    localparam int NUM_STAGES = DIV_STAGES + 5;

    localparam logic [31:0] ONE_Q24   = 32'h0100_0000;
    localparam logic [23:0] REC_LIMIT = 24'h02_0000;
    localparam logic [23:0] REM_START = 24'h01_0000;
    localparam logic [31:0] REC_SAT   = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN   = 32'h8000_0000;

    localparam logic [2:0] REG_OFFSET_X   = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z   = 3'd2;
    localparam logic [2:0] REG_MIN_R2     = 3'd3;
    localparam logic [2:0] REG_INNER_GAIN = 3'd4;
    localparam logic [2:0] REG_INNER_STEP = 3'd5;
    localparam logic [2:0] REG_MID_STEP   = 3'd6;
    localparam logic [2:0] REG_COLOR_EN   = 3'd7;

    localparam logic [1:0] BR_NONE  = 2'd0;
    localparam logic [1:0] BR_INNER = 2'd1;
    localparam logic [1:0] BR_INV   = 2'd2;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] coord_w;
        logic [31:0]        dist_scale_in;
        logic signed [31:0] color_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [31:0]        dist_scale_out;
        logic signed [31:0] color_out;
        logic [1:0]         fold_branch;
    } t_out_beat;

    typedef struct packed {
        logic [3:0][31:0] p;
        logic [31:0]      scale;
        logic [31:0]      color;
        logic [1:0]       branch;
    } t_carry;

    // signed 32 bit add or subtract, clamped to the signed range
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b,
                                            input logic sub);
        logic [32:0] s;
        s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31]) begin
            return s[32] ? S32_MIN : S32_MAX;
        end
        return s[31:0];
    endfunction

endpackage

[rtl/spherical_fold_with_offset_core.sv]
// spherical fold with offset: pipelined top level
//
// Input channel: i_valid / o_stall with the point, distance scale and colour in
// i_beat; a beat is taken on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with the result in o_beat, one result per beat.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; the
// port is always ready and is to be written by the user only while the pipeline is
// empty; the block does not enforce it. Stages to o_valid: squares, sum and branch,
// eight radix-2 divider stages of four quotient bits each (reciprocal of r2),
// the gain multipliers, scaling with saturation, and the offset removal.
// Throughput is one beat per cycle unless the output stalls; every stage holds a
// valid bit, moving when the next stage is empty or moving; bubbles close under a stall.
// When the receiver stalls, the output register holds its beat and the stages
// behind it keep filling; o_stall rises only once all 13 stages are full.
// Reset (i_rst_n low, synchronous) empties the pipeline and loads the register
// defaults: offsets 0, min_r2 0.25, inner_gain 4.0, colour steps 0, colour off.
module spherical_fold_with_offset_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sfold_pkg::t_in_beat i_beat,
    output logic                o_valid,
    input  logic                i_stall,
    output sfold_pkg::t_out_beat o_beat,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import sfold_pkg::*;

    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_D = 2;
    localparam int ST_M = ST_D + DIV_STAGES;
    localparam int ST_F = ST_M + 1;
    localparam int ST_O = ST_F + 1;

    // configuration registers
    logic [2:0][31:0] r_off;
    logic [24:0]      r_min_r2;
    logic [31:0]      r_inner_gain;
    logic [31:0]      r_inner_step;
    logic [31:0]      r_mid_step;
    logic             r_color_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off        <= '0;
            r_min_r2     <= 25'd4194304;
            r_inner_gain <= 32'd67108864;
            r_inner_step <= '0;
            r_mid_step   <= '0;
            r_color_en   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_OFFSET_X:   r_off[0]     <= i_cfg_data;
                REG_OFFSET_Y:   r_off[1]     <= i_cfg_data;
                REG_OFFSET_Z:   r_off[2]     <= i_cfg_data;
                REG_MIN_R2:     r_min_r2     <= i_cfg_data[24:0];
                REG_INNER_GAIN: r_inner_gain <= i_cfg_data;
                REG_INNER_STEP: r_inner_step <= i_cfg_data;
                REG_MID_STEP:   r_mid_step   <= i_cfg_data;
                REG_COLOR_EN:   r_color_en   <= i_cfg_data[0];
                default:        r_color_en   <= r_color_en;
            endcase
        end
    end

    // valid bits and move enables
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES:0]   en;

    always_comb begin
        en[NUM_STAGES] = !i_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[ST_O];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage A: squares and offset add
    logic [3:0][31:0]   in_c;
    logic signed [63:0] sq_full [4];
    logic [39:0]        n_a_sq [4];
    logic [39:0]        r_a_sq [4];
    t_carry             n_a_c;
    t_carry             r_a_c;

    assign in_c = {i_beat.coord_w, i_beat.coord_z, i_beat.coord_y, i_beat.coord_x};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sq_full[i] = $signed(in_c[i]) * $signed(in_c[i]);
            n_a_sq[i]  = sq_full[i][63:24];
        end
        n_a_c.p[0]   = sat_add(in_c[0], r_off[0], 1'b0);
        n_a_c.p[1]   = sat_add(in_c[1], r_off[1], 1'b0);
        n_a_c.p[2]   = sat_add(in_c[2], r_off[2], 1'b0);
        n_a_c.p[3]   = in_c[3];
        n_a_c.scale  = i_beat.dist_scale_in;
        n_a_c.color  = i_beat.color_in;
        n_a_c.branch = BR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_A]) begin
            r_a_sq <= n_a_sq;
            r_a_c  <= n_a_c;
        end
    end

    // stage B: squared length, branch pick
    logic [41:0] sum_b;
    logic [31:0] r2_b;
    t_carry      n_b_c;
    t_carry      r_b_c;
    logic [23:0] r_b_den;
    logic        r_b_rsat;

    always_comb begin
        sum_b = {2'b00, r_a_sq[0]} + {2'b00, r_a_sq[1]}
              + {2'b00, r_a_sq[2]} + {2'b00, r_a_sq[3]};
        r2_b  = (|sum_b[41:32]) ? 32'hFFFF_FFFF : sum_b[31:0];
        n_b_c = r_a_c;
        if (r2_b < {7'd0, r_min_r2}) begin
            n_b_c.branch = BR_INNER;
        end else if (r2_b < ONE_Q24) begin
            n_b_c.branch = BR_INV;
        end else begin
            n_b_c.branch = BR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_B]) begin
            r_b_c    <= n_b_c;
            r_b_den  <= r2_b[23:0];
            r_b_rsat <= (r2_b[23:0] <= REC_LIMIT);
        end
    end

    // divider stages: floor(2^48 / r2), four quotient bits per stage
    logic [23:0] r_d_rem  [DIV_STAGES];
    logic [31:0] r_d_q    [DIV_STAGES];
    logic [23:0] r_d_den  [DIV_STAGES];
    logic        r_d_rsat [DIV_STAGES];
    t_carry      r_d_c    [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        logic [23:0] src_rem;
        logic [31:0] src_q;
        logic [23:0] src_den;
        logic        src_rsat;
        t_carry      src_c;
        logic [23:0] n_rem;
        logic [31:0] n_q;

        if (k == 0) begin : g_first
            assign src_rem  = REM_START;
            assign src_q    = '0;
            assign src_den  = r_b_den;
            assign src_rsat = r_b_rsat;
            assign src_c    = r_b_c;
        end else begin : g_next
            assign src_rem  = r_d_rem[k-1];
            assign src_q    = r_d_q[k-1];
            assign src_den  = r_d_den[k-1];
            assign src_rsat = r_d_rsat[k-1];
            assign src_c    = r_d_c[k-1];
        end

        always_comb begin
            logic [24:0] t;
            n_rem = src_rem;
            n_q   = src_q;
            for (int j = 0; j < DIV_STEPS; j++) begin
                t = {n_rem, 1'b0};
                if (t >= {1'b0, src_den}) begin
                    t     = t - {1'b0, src_den};
                    n_rem = t[23:0];
                    n_q   = {n_q[30:0], 1'b1};
                end else begin
                    n_rem = t[23:0];
                    n_q   = {n_q[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_D+k]) begin
                r_d_rem[k]  <= n_rem;
                r_d_q[k]    <= n_q;
                r_d_den[k]  <= src_den;
                r_d_rsat[k] <= src_rsat;
                r_d_c[k]    <= src_c;
            end
        end
    end

    // stage M: gain select, products, colour step
    logic [31:0]        gain_m;
    logic signed [63:0] n_m_prod [4];
    logic signed [63:0] r_m_prod [4];
    logic signed [64:0] n_m_dprod;
    logic signed [64:0] r_m_dprod;
    t_carry             n_m_c;
    t_carry             r_m_c;
    t_carry             last_d;

    assign last_d = r_d_c[DIV_STAGES-1];

    always_comb begin
        case (last_d.branch)
            BR_INNER: gain_m = r_inner_gain;
            BR_INV:   gain_m = r_d_rsat[DIV_STAGES-1] ? REC_SAT : r_d_q[DIV_STAGES-1];
            default:  gain_m = '0;
        endcase
        for (int i = 0; i < 4; i++) begin
            n_m_prod[i] = $signed(last_d.p[i]) * $signed(gain_m);
        end
        n_m_dprod = $signed({1'b0, last_d.scale}) * $signed(gain_m);
        n_m_c     = last_d;
        if (r_color_en && last_d.branch == BR_INNER) begin
            n_m_c.color = sat_add(last_d.color, r_inner_step, 1'b0);
        end else if (r_color_en && last_d.branch == BR_INV) begin
            n_m_c.color = sat_add(last_d.color, r_mid_step, 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_M]) begin
            r_m_prod  <= n_m_prod;
            r_m_dprod <= n_m_dprod;
            r_m_c     <= n_m_c;
        end
    end

    // stage F: floor shift and saturation
    t_carry n_f_c;
    t_carry r_f_c;

    always_comb begin
        n_f_c = r_m_c;
        if (r_m_c.branch != BR_NONE) begin
            for (int i = 0; i < 4; i++) begin
                if (r_m_prod[i][63:55] != {9{r_m_prod[i][55]}}) begin
                    n_f_c.p[i] = r_m_prod[i][63] ? S32_MIN : S32_MAX;
                end else begin
                    n_f_c.p[i] = r_m_prod[i][55:24];
                end
            end
            if (r_m_dprod[64]) begin
                n_f_c.scale = '0;
            end else if (|r_m_dprod[63:56]) begin
                n_f_c.scale = 32'hFFFF_FFFF;
            end else begin
                n_f_c.scale = r_m_dprod[55:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_F]) begin
            r_f_c <= n_f_c;
        end
    end

    // stage O: offset removal into the output register
    t_out_beat n_o;
    t_out_beat r_o;

    always_comb begin
        n_o.out_x          = sat_add(r_f_c.p[0], r_off[0], 1'b1);
        n_o.out_y          = sat_add(r_f_c.p[1], r_off[1], 1'b1);
        n_o.out_z          = sat_add(r_f_c.p[2], r_off[2], 1'b1);
        n_o.out_w          = r_f_c.p[3];
        n_o.dist_scale_out = r_f_c.scale;
        n_o.color_out      = r_f_c.color;
        n_o.fold_branch    = r_f_c.branch;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_O]) begin
            r_o <= n_o;
        end
    end

    assign o_beat = r_o;

    // no fold means zero gain, so the scale product must vanish
    a_none_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_M] && r_m_c.branch == BR_NONE |-> r_m_dprod == '0)
        else $error("scale product nonzero without fold");

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_D] && r_d_c[0].branch == BR_INV && !r_d_rsat[0]
        |-> r_d_rem[0] < r_d_den[0])
        else $error("divider remainder out of range");

    // an unsaturated reciprocal fits in 31 bits
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_M-1] && last_d.branch == BR_INV && !r_d_rsat[DIV_STAGES-1]
        |-> !r_d_q[DIV_STAGES-1][31])
        else $error("reciprocal overflow");

    // input stalls only with a full pipeline behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_v) && i_stall)
        else $error("input stalled with room in the pipeline");

endmodule
